// ===== design/lsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types and constants for the decimal radix sorter: field widths,
// divide-by-ten constants, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
package lsd_pkg;

    // fixed field widths
    localparam int VALUE_W        = 31;
    localparam int TDATA_W        = 32;

    // parameter defaults
    localparam int DEPTH_DEF      = 32;
    localparam int VALUE_BITS_DEF = 31;

    // decimal digit handling
    localparam int RADIX          = 10;
    localparam int DIGIT_W        = 4;

    // reciprocal of ten, exact for any 32-bit dividend after a shift of 35
    localparam logic [31:0] DIV_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV_SHIFT = 35;

    // sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLR,
        ST_CNT_RD,
        ST_CNT_MUL,
        ST_CNT_UPD,
        ST_PFX,
        ST_SCT_RD,
        ST_SCT_WR,
        ST_CPY_RD,
        ST_CPY_WR,
        ST_EMIT_RD,
        ST_EMIT_PUT
    } state_t;

    // one element handed from the input side to the core
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [VALUE_W-1:0] value;
    } load_t;

    // one sorted element handed from the core to the output register
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [VALUE_W-1:0] value;
    } emit_t;

endpackage

// ===== design/lsd_decimal_radix_sort.sv =====
// ----------------------------------------------------------------------------
// lsd_decimal_radix_sort
// Stream sorter: collects a set of values closed by tlast, sorts it ascending
// by decimal LSD radix sort and streams the sorted set out with tlast.
// ----------------------------------------------------------------------------
// Loading takes one element per cycle; s_tready drops after the closing transfer.
// Sorting a set of n elements takes one pass per decimal digit of the
// largest value (none for an all-zero set), paced by the shared divide-by-ten
// unit and the element and scratch memories, each with one read and one write port.
// Results then leave in order, as the output register frees; then a new set loads.
// aresetn is synchronous, active low; it empties the set and the output stage.
module lsd_decimal_radix_sort
    import lsd_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [30:0] value, [31] zero pad
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [30:0] sorted_value, [31] zero pad
    output logic               m_tlast
);

    load_t              load;
    emit_t              emit;
    logic               load_ready;
    logic               out_free;
    logic               m_valid_reg;
    logic               m_last_reg;
    logic [VALUE_W-1:0] m_value_reg;

    // input transfer into the core
    assign s_tready   = load_ready;
    assign load.valid = s_tvalid & load_ready;
    assign load.last  = s_tlast;
    assign load.value = s_tdata[VALUE_W-1:0];

    lsd_sort_core #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .load_ready (load_ready),
        .out_free   (out_free),
        .emit       (emit)
    );

    // output register
    assign out_free = ~m_valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            m_value_reg <= emit.value;
            m_last_reg  <= emit.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_value_reg);
    assign m_tlast  = m_last_reg;

endmodule

// ===== design/lsd_div10.sv =====
// ----------------------------------------------------------------------------
// lsd_div10
// Shared divide-by-ten unit. The reciprocal product is registered; the
// quotient and the remainder digit come out in the cycle after the operand.
// ----------------------------------------------------------------------------
module lsd_div10
    import lsd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic [VALUE_BITS-1:0] operand,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [DIGIT_W-1:0]    remainder
);

    localparam int PROD_W = VALUE_BITS + 32;
    localparam int QUO_W  = PROD_W - DIV_SHIFT;

    logic [PROD_W-1:0]     prod_reg;
    logic [VALUE_BITS-1:0] operand_reg;
    logic [QUO_W-1:0]      quo_short;
    logic [VALUE_BITS-1:0] rem_full;

    // reciprocal multiply, registered
    always_ff @(posedge aclk) begin
        prod_reg    <= PROD_W'(operand) * PROD_W'(DIV_MAGIC);
        operand_reg <= operand;
    end

    // quotient from the high product bits, remainder by subtracting ten times it
    always_comb begin
        quo_short = prod_reg[PROD_W-1:DIV_SHIFT];
        quotient  = VALUE_BITS'(quo_short);
        rem_full  = operand_reg - (quotient << 3) - (quotient << 1);
        remainder = rem_full[DIGIT_W-1:0];
    end

endmodule

// ===== design/lsd_sort_core.sv =====
// ----------------------------------------------------------------------------
// lsd_sort_core
// Sequencer with element and scratch memories and the digit histogram.
// Collects a set, runs one counting-sort pass per decimal digit through the
// shared divide-by-ten unit, then reads the sorted set out in order.
// ----------------------------------------------------------------------------
module lsd_sort_core
    import lsd_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  load_t load,
    output logic  load_ready,
    input  logic  out_free,
    output emit_t emit
);

    localparam int CW     = $clog2(DEPTH + 1);
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ELEM_W = 2 * VALUE_BITS + DIGIT_W;
    localparam int SCR_W  = 2 * VALUE_BITS;

    // memories: element entry is {value, remaining quotient, current digit}
    logic [ELEM_W-1:0] elem_mem [DEPTH];
    logic [SCR_W-1:0]  scr_mem  [DEPTH];
    logic [ELEM_W-1:0] elem_rdata;
    logic [SCR_W-1:0]  scr_rdata;
    logic              elem_we;
    logic [AW-1:0]     elem_waddr;
    logic [ELEM_W-1:0] elem_wdata;
    logic              scr_we;
    logic [AW-1:0]     scr_waddr;
    logic [SCR_W-1:0]  scr_wdata;
    logic [AW-1:0]     rd_addr;

    // control state
    state_t                state_reg, state_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [DIGIT_W-1:0]    dig_reg, dig_next;
    logic [CW-1:0]         acc_reg, acc_next;
    logic                  more_reg, more_next;
    logic [CW-1:0]         cnt_reg  [RADIX];
    logic [CW-1:0]         cnt_next [RADIX];

    // datapath helpers
    logic [DIGIT_W-1:0]    cnt_sel;
    logic [CW-1:0]         cnt_rd;
    logic [CW-1:0]         cnt_dec;
    logic                  idx_last;
    logic [VALUE_BITS-1:0] in_value;
    logic [VALUE_BITS-1:0] e_value;
    logic [VALUE_BITS-1:0] e_quot;
    logic [DIGIT_W-1:0]    e_digit;
    logic [VALUE_BITS-1:0] s_value;
    logic [VALUE_BITS-1:0] s_quot;
    logic [VALUE_BITS-1:0] div_quo;
    logic [DIGIT_W-1:0]    div_rem;

    // shared divide-by-ten unit
    lsd_div10 #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div10 (
        .aclk      (aclk),
        .operand   (e_quot),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // element memory
    always_ff @(posedge aclk) begin
        if (elem_we) begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        elem_rdata <= elem_mem[rd_addr];
    end

    // scratch memory
    always_ff @(posedge aclk) begin
        if (scr_we) begin
            scr_mem[scr_waddr] <= scr_wdata;
        end
        scr_rdata <= scr_mem[rd_addr];
    end

    // field views of read data
    assign e_digit  = elem_rdata[DIGIT_W-1:0];
    assign e_quot   = elem_rdata[VALUE_BITS+DIGIT_W-1:DIGIT_W];
    assign e_value  = elem_rdata[ELEM_W-1:VALUE_BITS+DIGIT_W];
    assign s_quot   = scr_rdata[VALUE_BITS-1:0];
    assign s_value  = scr_rdata[SCR_W-1:VALUE_BITS];
    assign in_value = load.value[VALUE_BITS-1:0];

    assign rd_addr  = idx_reg[AW-1:0];
    assign idx_last = (idx_reg == CW'(fill_reg - 1'b1));
    assign cnt_rd   = cnt_reg[cnt_sel];
    assign cnt_dec  = cnt_rd - 1'b1;

    // state and counter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            fill_reg  <= '0;
            idx_reg   <= '0;
            dig_reg   <= '0;
            acc_reg   <= '0;
            more_reg  <= 1'b0;
            for (int k = 0; k < RADIX; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            dig_reg   <= dig_next;
            acc_reg   <= acc_next;
            more_reg  <= more_next;
            for (int k = 0; k < RADIX; k++) begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        dig_next   = dig_reg;
        acc_next   = acc_reg;
        more_next  = more_reg;
        for (int k = 0; k < RADIX; k++) begin
            cnt_next[k] = cnt_reg[k];
        end
        cnt_sel    = dig_reg;
        elem_we    = 1'b0;
        elem_waddr = idx_reg[AW-1:0];
        elem_wdata = {e_value, div_quo, div_rem};
        scr_we     = 1'b0;
        scr_waddr  = cnt_dec[AW-1:0];
        scr_wdata  = {e_value, e_quot};
        load_ready = 1'b0;
        emit       = '0;

        unique case (state_reg)
            // collect elements, dropping any beyond the store depth
            ST_LOAD: begin
                load_ready = 1'b1;
                if (load.valid) begin
                    if (fill_reg != CW'(DEPTH)) begin
                        elem_we    = 1'b1;
                        elem_waddr = fill_reg[AW-1:0];
                        elem_wdata = {in_value, in_value, DIGIT_W'(0)};
                        fill_next  = fill_reg + 1'b1;
                        more_next  = more_reg | (in_value != '0);
                    end
                    if (load.last) begin
                        idx_next   = '0;
                        state_next = more_next ? ST_CLR : ST_EMIT_RD;
                    end
                end
            end
            // start of a pass: clear histogram
            ST_CLR: begin
                for (int k = 0; k < RADIX; k++) begin
                    cnt_next[k] = '0;
                end
                more_next  = 1'b0;
                idx_next   = '0;
                state_next = ST_CNT_RD;
            end
            ST_CNT_RD: begin
                state_next = ST_CNT_MUL;
            end
            // read data feeds the divider this cycle
            ST_CNT_MUL: begin
                state_next = ST_CNT_UPD;
            end
            // record digit and next quotient, bump the histogram
            ST_CNT_UPD: begin
                cnt_sel           = div_rem;
                cnt_next[div_rem] = cnt_rd + 1'b1;
                elem_we           = 1'b1;
                more_next         = more_reg | (div_quo != '0);
                if (idx_last) begin
                    dig_next   = '0;
                    acc_next   = '0;
                    state_next = ST_PFX;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_CNT_RD;
                end
            end
            // running prefix sum, one digit a cycle
            ST_PFX: begin
                cnt_sel           = dig_reg;
                acc_next          = acc_reg + cnt_rd;
                cnt_next[dig_reg] = acc_next;
                if (dig_reg == DIGIT_W'(RADIX - 1)) begin
                    idx_next   = CW'(fill_reg - 1'b1);
                    state_next = ST_SCT_RD;
                end else begin
                    dig_next = dig_reg + 1'b1;
                end
            end
            ST_SCT_RD: begin
                state_next = ST_SCT_WR;
            end
            // scatter from the top down to keep the pass stable
            ST_SCT_WR: begin
                cnt_sel           = e_digit;
                cnt_next[e_digit] = cnt_dec;
                scr_we            = 1'b1;
                if (idx_reg == '0) begin
                    state_next = ST_CPY_RD;
                end else begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_SCT_RD;
                end
            end
            ST_CPY_RD: begin
                state_next = ST_CPY_WR;
            end
            // copy the pass result back into the element store
            ST_CPY_WR: begin
                elem_we    = 1'b1;
                elem_wdata = {s_value, s_quot, DIGIT_W'(0)};
                if (idx_last) begin
                    idx_next   = '0;
                    state_next = more_reg ? ST_CLR : ST_EMIT_RD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_CPY_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_PUT;
            end
            // hand one sorted element to the output register
            ST_EMIT_PUT: begin
                if (out_free) begin
                    emit.valid = 1'b1;
                    emit.last  = idx_last;
                    emit.value = VALUE_W'(e_value);
                    if (idx_last) begin
                        fill_next  = '0;
                        more_next  = 1'b0;
                        idx_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule
